// File: src/modular_exponentiation_64_defines.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_64 assertion macros
// concurrent checks on clk, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_64_DEFINES_SVH
`define MODULAR_EXPONENTIATION_64_DEFINES_SVH

`ifndef SYNTHESIS
`define ME64_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("modexp check failed");
`define ME64_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("modexp check failed");
`else
`define ME64_ASSERT(label, prop)
`define ME64_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: src/me64_pkg.sv
// ----------------------------------------------------------------------------
// me64_pkg
// widths and register indexes of the modular exponentiation block
// ----------------------------------------------------------------------------
`default_nettype none

package me64_pkg;

    localparam int PORT_WIDTH      = 64;
    localparam int OPERAND_WIDTH   = 64;
    localparam int CNT_WIDTH       = $clog2(OPERAND_WIDTH);
    localparam int CFG_INDEX_WIDTH = 8;

    typedef logic [OPERAND_WIDTH-1:0]   operand_t;
    typedef logic [OPERAND_WIDTH+1:0]   wide_sum_t;
    typedef logic [CNT_WIDTH-1:0]       bit_cnt_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODULUS  = cfg_index_t'(0);
    localparam cfg_index_t REG_EXPONENT = cfg_index_t'(1);

endpackage

`default_nettype wire

// File: src/modular_exponentiation_64.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_64
// base^exponent mod modulus, right-to-left square-and-multiply on one
// bit-serial modular multiply unit (one double-and-add step per cycle)
// zero modulus skips to done with modulus_error set; else base reduction, then multiplies
// one request at a time; next start taken the cycle after done
// the base reduction and each multiply run 64 double-and-add steps
// async active-low reset: idle, modulus 1, exponent 0; results cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_64_defines.svh"

module modular_exponentiation_64
    import me64_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [PORT_WIDTH-1:0] base_value,
    // result channel
    output logic                       done,
    output logic [PORT_WIDTH-1:0]      power_result,
    output logic                       modulus_error,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire cfg_index_t            cfg_index,
    input  wire logic [PORT_WIDTH-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam bit_cnt_t CNT_TOP = bit_cnt_t'(OPERAND_WIDTH - 1);

    logic [2:0] state_reg, state_next;
    operand_t   mod_reg, mod_next;
    operand_t   exp_reg, exp_next;
    operand_t   acc_reg, acc_next;
    operand_t   sq_reg, sq_next;
    operand_t   shift_reg, shift_next;
    operand_t   r_reg, r_next;
    bit_cnt_t   cnt_reg, cnt_next;
    logic       err_reg, err_next;

    logic       b_bit;
    logic       cnt_last;
    logic       accept;
    operand_t   addend;
    operand_t   r_new;
    operand_t   shift_down;
    wide_sum_t  sum;
    wide_sum_t  mod_x1;
    wide_sum_t  mod_x2;
    wide_sum_t  sum_red;

    assign accept     = start && !busy;
    assign b_bit      = sq_reg[cnt_reg];
    assign cnt_last   = (cnt_reg == '0);
    assign shift_down = shift_reg >> 1;

    // shared unit: r <- (2r + addend) mod m, sum stays below 3m
    always_comb
    begin
        unique case (state_reg)
            ST_REDUCE: addend = operand_t'(b_bit);
            ST_MUL:    addend = b_bit ? acc_reg : '0;
            ST_SQR:    addend = b_bit ? sq_reg : '0;
            default:   addend = '0;
        endcase
    end

    assign mod_x1 = {2'b00, mod_reg};
    assign mod_x2 = {1'b0, mod_reg, 1'b0};
    assign sum    = {1'b0, r_reg, 1'b0} + {2'b00, addend};

    always_comb
    begin
        if (sum >= mod_x2)
        begin
            sum_red = sum - mod_x2;
        end
        else if (sum >= mod_x1)
        begin
            sum_red = sum - mod_x1;
        end
        else
        begin
            sum_red = sum;
        end
    end

    assign r_new = sum_red[OPERAND_WIDTH-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mod_next   = mod_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        shift_next = shift_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MODULUS)
            begin
                mod_next = cfg_data[OPERAND_WIDTH-1:0];
            end
            else if (cfg_index == REG_EXPONENT)
            begin
                exp_next = cfg_data[OPERAND_WIDTH-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mod_reg == '0)
                    begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        sq_next    = base_value[OPERAND_WIDTH-1:0];
                        shift_next = exp_reg;
                        r_next     = '0;
                        cnt_next   = CNT_TOP;
                        // zero exponent gives 1 unreduced
                        acc_next   = ((exp_reg == '0) || (mod_reg != operand_t'(1)))
                                     ? operand_t'(1) : '0;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                r_next   = r_new;
                cnt_next = cnt_reg - bit_cnt_t'(1);
                if (cnt_last)
                begin
                    sq_next  = r_new;
                    r_next   = '0;
                    cnt_next = CNT_TOP;
                    if (shift_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (shift_reg[0])
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        shift_next = shift_down;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_MUL:
            begin
                r_next   = r_new;
                cnt_next = cnt_reg - bit_cnt_t'(1);
                if (cnt_last)
                begin
                    acc_next   = r_new;
                    r_next     = '0;
                    cnt_next   = CNT_TOP;
                    shift_next = shift_down;
                    // final squaring is skipped, it cannot reach the result
                    state_next = (shift_down == '0) ? ST_DONE : ST_SQR;
                end
            end
            ST_SQR:
            begin
                r_next   = r_new;
                cnt_next = cnt_reg - bit_cnt_t'(1);
                if (cnt_last)
                begin
                    sq_next  = r_new;
                    r_next   = '0;
                    cnt_next = CNT_TOP;
                    if (shift_reg[0])
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        shift_next = shift_down;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mod_reg   <= operand_t'(1);
            exp_reg   <= '0;
            err_reg   <= 1'b0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            sq_reg    <= '0;
            shift_reg <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mod_reg   <= mod_next;
            exp_reg   <= exp_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            sq_reg    <= sq_next;
            shift_reg <= shift_next;
            r_reg     <= r_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign cfg_ready     = !busy;
    assign power_result  = PORT_WIDTH'(acc_reg);
    assign modulus_error = err_reg;

    `ME64_ASSERT(a_accept_busy, (start && !busy) |=> busy)
    `ME64_ASSERT(a_done_idle, done |=> !busy)
    `ME64_ASSERT(a_err_zero, (done && modulus_error) |-> (power_result == '0))
    `ME64_ASSERT(a_rem_below_mod,
        ((state_reg == ST_REDUCE) || (state_reg == ST_MUL) || (state_reg == ST_SQR))
        |-> (r_reg < mod_reg))
    `ME64_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> (!busy && !done))

endmodule

`default_nettype wire

// File: bench/tb_modular_exponentiation_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_64
// runs a table of corner requests, then groups of random requests under
// changing modulus and exponent settings and sender gaps; every result is
// checked against the expected value in its table row or a square-and-multiply
// model built on 128-bit products

module tb_modular_exponentiation_64
    import me64_pkg::*;
();

    localparam int         STALL_LIMIT   = 40000;
    localparam int         SETTLE_CYCLES = 200;
    localparam int         GROUPS        = 20;
    localparam int         GROUP_ITEMS   = 5;
    localparam int         IDLE_PCT [4]  = '{0, 47, 0, 35};
    localparam cfg_index_t REG_UNUSED    = cfg_index_t'(2);
    localparam cfg_index_t REG_INDEX_TOP = '1;
    localparam operand_t   ALL_ONES      = '1;

    typedef struct packed {
        operand_t value;
        logic     err;
    } power_t;

    typedef struct packed {
        logic     load_regs;
        operand_t modulus;
        operand_t exponent;
        logic     poke_unused;
        operand_t base;
        logic     typed;
        operand_t want;
        logic     want_err;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;
    localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // reset settings: modulus 1, exponent 0
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'd12345, 1'b1, 64'd1, 1'b0},
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd1, 1'b0},
        // zero modulus flags an error for any exponent
        '{1'b1, 64'd0, 64'd0, 1'b0, 64'd5, 1'b1, 64'd0, 1'b1},
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b1},
        '{1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b1, 64'd0, 1'b1},
        // modulus 1: zero unless the exponent is zero
        '{1'b1, 64'd1, 64'd3, 1'b1, 64'd7, 1'b1, 64'd0, 1'b0},
        '{1'b1, 64'd1, 64'd0, 1'b0, 64'd0, 1'b1, 64'd1, 1'b0},
        // all-ones modulus, base at and just below it
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 64'd0, 1'b0},
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE,
          1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE,
          1'b1, 64'd1, 1'b0},
        // full 64-bit odd exponent on minus one
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 64'd0, 1'b1, 64'd1, 1'b0},
        '{1'b1, 64'd1000, 64'd5, 1'b0, 64'd0, 1'b1, 64'd0, 1'b0},
        // base above the modulus gets reduced first
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'd1003, 1'b1, 64'd243, 1'b0},
        '{1'b1, 64'h8000_0000_0000_0000, 64'd3, 1'b0, 64'd3, 1'b1, 64'd27, 1'b0},
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'h8000_0000_0000_0003, 1'b1, 64'd27, 1'b0},
        '{1'b1, 64'd13, 64'h8000_0000_0000_0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b0, 64'd0, 1'b0},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 1'b0, 64'd2,
          1'b0, 64'd0, 1'b0},
        '{1'b0, 64'd0, 64'd0, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0, 1'b0},
        '{1'b1, 64'd2, 64'd1, 1'b0, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 1'b0},
        '{1'b1, 64'hDEAD_BEEF_0BAD_F00D, 64'h0000_0000_0001_2345, 1'b0,
          64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PORT_WIDTH-1:0] base_value;
    logic                  done;
    logic [PORT_WIDTH-1:0] power_result;
    logic                  modulus_error;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [PORT_WIDTH-1:0] cfg_data;

    operand_t reg_modulus  = operand_t'(1);
    operand_t reg_exponent = '0;
    power_t   power_expected [$];
    int       mismatches   = 0;
    int       idle_cycles  = 0;

    modular_exponentiation_64 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .base_value    (base_value),
        .done          (done),
        .power_result  (power_result),
        .modulus_error (modulus_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic operand_t rand_operand();
        return {$urandom, $urandom};
    endfunction

    // exact (a * b) mod m through a double-width product
    function automatic operand_t mul_reduce(operand_t a, operand_t b, operand_t m);
        logic [2*OPERAND_WIDTH-1:0] product;
        product = {{OPERAND_WIDTH{1'b0}}, a} * {{OPERAND_WIDTH{1'b0}}, b};
        return operand_t'(product % {{OPERAND_WIDTH{1'b0}}, m});
    endfunction

    function automatic power_t predict_power(operand_t base);
        power_t   res;
        operand_t acc;
        operand_t sq;
        operand_t e;
        res.value = '0;
        res.err   = 1'b1;
        if (reg_modulus == '0)
            return res;
        acc = operand_t'(1);
        sq  = base % reg_modulus;
        e   = reg_exponent;
        while (e != '0)
        begin
            if (e[0])
                acc = mul_reduce(acc % reg_modulus, sq, reg_modulus);
            e  = e >> 1;
            sq = mul_reduce(sq, sq, reg_modulus);
        end
        res.value = acc;
        res.err   = 1'b0;
        return res;
    endfunction

    // leaves cfg_valid high so back-to-back writes run without a gap between them
    task automatic write_reg(input cfg_index_t idx, input operand_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODULUS:  reg_modulus  = data;
            REG_EXPONENT: reg_exponent = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (power_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_regs(input operand_t m, input operand_t e, input bit poke);
        drain();
        write_reg(REG_MODULUS, m);
        write_reg(REG_EXPONENT, e);
        // writes past the register list must leave both registers alone
        if (poke)
        begin
            write_reg(REG_UNUSED, rand_operand());
            write_reg(REG_INDEX_TOP, rand_operand());
        end
        cfg_valid <= 1'b0;
    endtask

    // start stays high afterwards; the caller lowers it when it goes idle
    task automatic send_base(input operand_t base, input power_t want);
        start      <= 1'b1;
        base_value <= base;
        do @(posedge clk); while (busy);
        power_expected.push_back(want);
    endtask

    always @(posedge clk)
    begin : check_result
        power_t want;
        if (rst_n && done)
        begin
            if (power_expected.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request pending: power_result %h modulus_error %b",
                         $time, power_result, modulus_error);
            end
            else
            begin
                want = power_expected.pop_front();
                if (power_result !== want.value)
                begin
                    mismatches++;
                    $display("%0t: power_result mismatch: expected %h actual %h",
                             $time, want.value, power_result);
                end
                if (modulus_error !== want.err)
                begin
                    mismatches++;
                    $display("%0t: modulus_error mismatch: expected %b actual %b",
                             $time, want.err, modulus_error);
                end
            end
        end
    end

    // counts cycles in which no request, result or register write goes through
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_modular_exponentiation_64: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        directed_row_t row;
        power_t        want;
        operand_t      m;
        operand_t      e;
        operand_t      b;
        int            idle_pct;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        base_value <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.load_regs)
                load_regs(row.modulus, row.exponent, row.poke_unused);
            if (row.typed)
            begin
                want.value = row.want;
                want.err   = row.want_err;
            end
            else
                want = predict_power(row.base);
            send_base(row.base, want);
        end

        for (int g = 0; g < GROUPS; g++)
        begin
            case ($urandom_range(0, 9))
                0:       m = '0;
                1:       m = operand_t'(1);
                2:       m = ALL_ONES;
                3:       m = operand_t'($urandom_range(2, 1000));
                4:       m = rand_operand() | (operand_t'(1) << (OPERAND_WIDTH - 1));
                default: m = rand_operand();
            endcase
            // long exponents are slow to run, so keep them rare
            case ($urandom_range(0, 9))
                0:       e = '0;
                1:       e = rand_operand();
                2, 3, 4: e = rand_operand() >> $urandom_range(32, 63);
                default: e = rand_operand() >> $urandom_range(54, 63);
            endcase
            load_regs(m, e, $urandom_range(0, 3) == 0);
            idle_pct = IDLE_PCT[g / (GROUPS / 4)];
            repeat (GROUP_ITEMS)
            begin
                while ($urandom_range(1, 100) <= idle_pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                case ($urandom_range(0, 7))
                    0:       b = '0;
                    1:       b = ALL_ONES;
                    2:       b = (reg_modulus != '0) ? rand_operand() % reg_modulus
                                                     : rand_operand();
                    default: b = rand_operand();
                endcase
                send_base(b, predict_power(b));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_modular_exponentiation_64: PASS");
        else
            $display("tb_modular_exponentiation_64: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/me64_pkg.sv
src/modular_exponentiation_64.sv
bench/tb_modular_exponentiation_64.sv
